/* sv/fpw_pkg.sv */
// fpw_pkg: shared types and constants for the four-level page table walker
// no dependencies
package fpw_pkg;

  localparam int VADDR_W    = 48;
  localparam int ENTRY_W    = 64;
  localparam int ADDR_W     = 52;
  localparam int FRAME_W    = 40;
  localparam int PAGE_SHIFT = 12;
  localparam int INDEX_BITS = 9;
  localparam int ENTRY_SHIFT = PAGE_SHIFT - INDEX_BITS;

  localparam int LEVELS_DEF = 4;

  localparam int QUEUE_DEPTH = 2;

  localparam int PRESENT_BIT = 0;
  localparam int USER_BIT    = 2;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_STRAY = 2'd2;

  localparam logic [1:0] FAULT_LEVEL_MAX = 2'd3;

  // classified input transaction: translate address or returned entry
  typedef struct packed {
    logic               is_req;
    logic [ENTRY_W-1:0] data;
  } item_t;

endpackage

/* sv/fpw_if.sv */
// fpw_if: valid/ready channel interfaces for walker input and result transactions
// depends on fpw_pkg
interface fpw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [fpw_pkg::VADDR_W-1:0] virt_addr;
  logic [fpw_pkg::ENTRY_W-1:0] read_data;

  modport source (output valid, output req_type, output virt_addr, output read_data,
                  input ready);
  modport sink (input valid, input req_type, input virt_addr, input read_data,
                output ready);
endinterface

interface fpw_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  result_kind;
  logic [fpw_pkg::ADDR_W-1:0]  entry_addr;
  logic [fpw_pkg::ENTRY_W-1:0] leaf_entry;
  logic                        fault;
  logic [1:0]                  fault_level;

  modport source (output valid, output result_kind, output entry_addr, output leaf_entry,
                  output fault, output fault_level, input ready);
  modport sink (input valid, input result_kind, input entry_addr, input leaf_entry,
                input fault, input fault_level, output ready);
endinterface

/* sv/fpw_front.sv */
// fpw_front: accepts input transactions, classifies them and packs the payload
// depends on fpw_pkg and fpw_if
module fpw_front (
  fpw_in_if.sink          in_ch,
  input  logic            queue_full,
  output logic            push,
  output fpw_pkg::item_t  push_item
);
  import fpw_pkg::*;

  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full;

  always_comb begin
    push_item.is_req = (in_ch.req_type == REQ_TRANSLATE);
    if (push_item.is_req) begin
      push_item.data = ENTRY_W'(in_ch.virt_addr);
    end else begin
      push_item.data = in_ch.read_data;
    end
  end

endmodule

/* sv/fpw_queue.sv */
// fpw_queue: short fifo of classified transactions between front and back
// depends on fpw_pkg
module fpw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpw_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output fpw_pkg::item_t  head_item,
  output logic            empty
);
  import fpw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/fpw_back.sv */
// fpw_back: walk state, entry checks, next read address and registered result
// depends on fpw_pkg and fpw_if
module fpw_back #(
  parameter int LEVELS = fpw_pkg::LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [fpw_pkg::FRAME_W-1:0]  cfg_wr_data,
  input  fpw_pkg::item_t               head_item,
  input  logic                         queue_empty,
  output logic                         pop,
  fpw_out_if.source                    out_ch
);
  import fpw_pkg::*;

  localparam int LW     = $clog2(LEVELS);
  localparam int NSLOT  = 2 ** LW;
  localparam int EXT_W  = PAGE_SHIFT + INDEX_BITS * LEVELS;

  logic [FRAME_W-1:0] root_frame;
  logic               walk_busy;
  logic [LW-1:0]      walk_level;
  logic [VADDR_W-1:0] saved_vaddr;

  logic               walk_busy_next;
  logic [LW-1:0]      walk_level_next;
  logic [VADDR_W-1:0] saved_vaddr_next;

  logic [1:0]         kind_next;
  logic [ADDR_W-1:0]  addr_next;
  logic [ENTRY_W-1:0] leaf_next;
  logic               fault_next;
  logic [1:0]         flevel_next;

  logic               is_last;
  logic               entry_ok;
  logic [VADDR_W-1:0] idx_vaddr;
  logic [EXT_W-1:0]   idx_ext;
  logic [LW-1:0]      idx_level;
  logic [INDEX_BITS-1:0] idx_table [NSLOT];
  logic [INDEX_BITS-1:0] cur_index;
  logic [ENTRY_W-1:0] entry;

  assign pop   = !queue_empty && (!out_ch.valid || out_ch.ready);
  assign entry = head_item.data;

  assign is_last  = (walk_level == LW'(LEVELS - 1));
  assign entry_ok = is_last ? (entry[PRESENT_BIT] && entry[USER_BIT]) : entry[PRESENT_BIT];

  assign idx_vaddr = head_item.is_req ? entry[VADDR_W-1:0] : saved_vaddr;
  assign idx_level = head_item.is_req ? '0 : walk_level + 1'b1;
  assign idx_ext   = EXT_W'(idx_vaddr);

  // index of each level, top level at the highest address bits
  for (genvar l = 0; l < NSLOT; l++) begin : g_index
    if (l < LEVELS) begin : g_used
      assign idx_table[l] =
        idx_ext[PAGE_SHIFT + INDEX_BITS * (LEVELS - 1 - l) +: INDEX_BITS];
    end else begin : g_unused
      assign idx_table[l] = '0;
    end
  end

  assign cur_index = idx_table[idx_level];

  always_comb begin
    walk_busy_next   = walk_busy;
    walk_level_next  = walk_level;
    saved_vaddr_next = saved_vaddr;
    kind_next        = KIND_STRAY;
    addr_next        = '0;
    leaf_next        = '0;
    fault_next       = 1'b0;
    flevel_next      = '0;
    if (head_item.is_req) begin
      kind_next        = KIND_READ;
      addr_next        = {root_frame, cur_index, {ENTRY_SHIFT{1'b0}}};
      walk_busy_next   = 1'b1;
      walk_level_next  = '0;
      saved_vaddr_next = entry[VADDR_W-1:0];
    end else if (!walk_busy) begin
      kind_next = KIND_STRAY;
    end else if (!entry_ok) begin
      kind_next       = KIND_DONE;
      fault_next      = 1'b1;
      flevel_next     = (32'(walk_level) > 32'(FAULT_LEVEL_MAX)) ? FAULT_LEVEL_MAX
                                                                 : 2'(walk_level);
      walk_busy_next  = 1'b0;
      walk_level_next = '0;
    end else if (!is_last) begin
      kind_next       = KIND_READ;
      addr_next       = {entry[ADDR_W-1:PAGE_SHIFT], cur_index, {ENTRY_SHIFT{1'b0}}};
      walk_level_next = walk_level + 1'b1;
    end else begin
      kind_next       = KIND_DONE;
      leaf_next       = entry;
      walk_busy_next  = 1'b0;
      walk_level_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame   <= '0;
      walk_busy    <= 1'b0;
      walk_level   <= '0;
      saved_vaddr  <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        root_frame <= cfg_wr_data;
      end
      if (pop) begin
        walk_busy    <= walk_busy_next;
        walk_level   <= walk_level_next;
        saved_vaddr  <= saved_vaddr_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // result payload, loaded when a transaction leaves the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.result_kind <= kind_next;
      out_ch.entry_addr  <= addr_next;
      out_ch.leaf_entry  <= leaf_next;
      out_ch.fault       <= fault_next;
      out_ch.fault_level <= flevel_next;
    end
  end

endmodule

/* sv/four_level_page_walk.sv */
// four_level_page_walk: page table walker top level, front, queue and back
// depends on fpw_pkg, fpw_if, fpw_front, fpw_queue, fpw_back
// an accepted input is written into the queue, and its result is registered at the output as it leaves the queue
// throughput: one transaction per cycle while the result side is not stalled
// the two-entry queue absorbs a stall on the result side before input ready drops
// reset: walk idle at level 0, root_frame 0, queue empty, no result pending
module four_level_page_walk #(
  parameter int LEVELS = fpw_pkg::LEVELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [fpw_pkg::FRAME_W-1:0] cfg_wr_data,
  fpw_in_if.sink                      in_ch,
  fpw_out_if.source                   out_ch
);
  import fpw_pkg::*;

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  queue_empty;
  logic  pop;
  item_t head_item;

  fpw_front u_front (
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  fpw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head_item (head_item),
    .empty     (queue_empty)
  );

  fpw_back #(
    .LEVELS (LEVELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head_item   (head_item),
    .queue_empty (queue_empty),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking testbench for the four-level page table walker
// drives translate requests and table entries over valid/ready with random idling
// depends on fpw_pkg, fpw_if and four_level_page_walk
`timescale 1ns / 100ps

module tb_top;
  import fpw_pkg::*;

  localparam int LEVELS = LEVELS_DEF;
  localparam int MAX_GAP = 11;

  typedef struct {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] leaf;
    logic               fault;
    logic [1:0]         flevel;
  } walk_result_t;

  class walk_scoreboard;
    logic [FRAME_W-1:0] root_frame;
    bit                 busy;
    int unsigned        level;
    logic [VADDR_W-1:0] vaddr;
    walk_result_t       pending[$];
    int                 errors;

    function new();
      root_frame = '0;
      busy = 0;
      level = 0;
      vaddr = '0;
      errors = 0;
    endfunction

    function logic [ADDR_W-1:0] entry_offset(int unsigned lvl);
      int unsigned shift;
      logic [ADDR_W-1:0] idx;
      shift = PAGE_SHIFT + INDEX_BITS * (LEVELS - 1 - lvl);
      if (shift >= 64) return '0;
      idx = ADDR_W'(vaddr >> shift) & ADDR_W'((1 << INDEX_BITS) - 1);
      return idx << ENTRY_SHIFT;
    endfunction

    function void note_input(logic rt, logic [VADDR_W-1:0] va, logic [ENTRY_W-1:0] rd);
      walk_result_t r;
      bit ok;
      r = '{default: '0};
      if (rt == REQ_TRANSLATE) begin
        vaddr = va;
        busy = 1;
        level = 0;
        r.kind = KIND_READ;
        r.addr = {root_frame, {PAGE_SHIFT{1'b0}}} + entry_offset(0);
      end else if (!busy) begin
        r.kind = KIND_STRAY;
      end else begin
        if (level + 1 < LEVELS) ok = rd[PRESENT_BIT];
        else ok = rd[PRESENT_BIT] && rd[USER_BIT];
        if (!ok) begin
          r.kind = KIND_DONE;
          r.fault = 1'b1;
          r.flevel = (level > 3) ? FAULT_LEVEL_MAX : 2'(level);
          busy = 0;
          level = 0;
        end else if (level + 1 < LEVELS) begin
          level++;
          r.kind = KIND_READ;
          r.addr = {rd[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} + entry_offset(level);
        end else begin
          busy = 0;
          level = 0;
          r.kind = KIND_DONE;
          r.leaf = rd;
        end
      end
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [ADDR_W-1:0] addr,
                               logic [ENTRY_W-1:0] leaf, logic flt, logic [1:0] flevel);
      walk_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual kind %0d addr %h leaf %h",
                 $time, kind, addr, leaf);
        return;
      end
      e = pending.pop_front();
      compare_field("result_kind", 64'(e.kind), 64'(kind));
      compare_field("entry_addr", 64'(e.addr), 64'(addr));
      compare_field("leaf_entry", e.leaf, leaf);
      compare_field("fault", 64'(e.fault), 64'(flt));
      compare_field("fault_level", 64'(e.flevel), 64'(flevel));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [FRAME_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_rt = REQ_TRANSLATE;
  logic [VADDR_W-1:0] in_va = '0;
  logic [ENTRY_W-1:0] in_rd = '0;
  logic               out_ready = 1'b0;
  int                 out_stall = 0;
  int                 sent = 0;
  bit                 idle_off = 0;
  walk_scoreboard     sb = new();

  fpw_in_if  in_ch();
  fpw_out_if out_ch();

  assign in_ch.valid     = in_valid;
  assign in_ch.req_type  = in_rt;
  assign in_ch.virt_addr = in_va;
  assign in_ch.read_data = in_rd;
  assign out_ch.ready    = out_ready;

  four_level_page_walk #(.LEVELS(LEVELS)) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #4 clk = ~clk;

  function automatic int draw_gap();
    return idle_off ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ready) begin
      sb.check_result(out_ch.result_kind, out_ch.entry_addr, out_ch.leaf_entry,
                      out_ch.fault, out_ch.fault_level);
      out_stall = draw_gap();
    end
    if (!rst && in_valid && in_ch.ready) sb.note_input(in_rt, in_va, in_rd);
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ready = 1'b0;
      out_stall--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic rt, logic [VADDR_W-1:0] va, logic [ENTRY_W-1:0] rd);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_rt = rt;
    in_va = va;
    in_rd = rd;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_root(logic [FRAME_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.root_frame = value;
  endtask

  task automatic directed_walks();
    int i;
    // stray response while idle
    send_item(REQ_RESPONSE, '1, '1);
    // restart while busy, then a full walk over all-ones entries
    send_item(REQ_TRANSLATE, '0, '0);
    send_item(REQ_RESPONSE, '0, '1);
    send_item(REQ_TRANSLATE, '1, '0);
    for (i = 0; i < LEVELS; i++) send_item(REQ_RESPONSE, '0, '1);
    // not present at the top
    send_item(REQ_TRANSLATE, '1, '0);
    send_item(REQ_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);
    // not present one level down
    send_item(REQ_TRANSLATE, 48'h8040_2010_0ABC, '0);
    send_item(REQ_RESPONSE, '0, 64'h0000_0000_1234_5001);
    send_item(REQ_RESPONSE, '0, 64'h0000_0000_0000_0000);
    // not present two levels down
    send_item(REQ_TRANSLATE, 48'h7FBF_DFEF_F543, '0);
    send_item(REQ_RESPONSE, '0, 64'h1);
    send_item(REQ_RESPONSE, '0, 64'h3);
    send_item(REQ_RESPONSE, '0, 64'h8000_0000_0000_0FFE);
    // leaf present but not user
    send_item(REQ_TRANSLATE, 48'h0000_FFFF_F000, '0);
    for (i = 0; i < LEVELS - 1; i++) send_item(REQ_RESPONSE, '0, 64'h000F_FFFF_FFFF_F001);
    send_item(REQ_RESPONSE, '0, 64'h1);
    // leaf user but not present
    send_item(REQ_TRANSLATE, 48'hFFFF_0000_0FFF, '0);
    for (i = 0; i < LEVELS - 1; i++) send_item(REQ_RESPONSE, '0, 64'h0000_0000_0000_1001);
    send_item(REQ_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFE);
  endtask

  task automatic random_walk();
    logic [ENTRY_W-1:0] ent;
    int lvl;
    send_item(REQ_TRANSLATE, VADDR_W'(rand64()), rand64());
    for (lvl = 0; lvl < LEVELS; lvl++) begin
      if ($urandom_range(0, 19) == 0) return;
      ent = rand64();
      if ($urandom_range(0, 9) != 0) begin
        ent[PRESENT_BIT] = 1'b1;
        if (lvl == LEVELS - 1) ent[USER_BIT] = 1'b1;
      end
      send_item(REQ_RESPONSE, VADDR_W'(rand64()), ent);
      if (!ent[PRESENT_BIT] || (lvl == LEVELS - 1 && !ent[USER_BIT])) return;
    end
  endtask

  initial begin
    int phase;
    int target;
    logic [FRAME_W-1:0] root;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    write_root('1);
    directed_walks();
    drain();
    for (phase = 0; phase < 5; phase++) begin
      idle_off = (phase == 2);
      case (phase)
        0: root = '0;
        1: root = '1;
        default: root = FRAME_W'(rand64());
      endcase
      write_root(root);
      target = sent + 400;
      while (sent < target) begin
        if ($urandom_range(0, 4) == 0)
          send_item(1'($urandom_range(0, 1)), VADDR_W'(rand64()), rand64());
        else
          random_walk();
      end
      drain();
    end
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
sv/fpw_pkg.sv
sv/fpw_if.sv
sv/fpw_front.sv
sv/fpw_queue.sv
sv/fpw_back.sv
sv/four_level_page_walk.sv
sim/tb_top.sv
